>>> design/scmap_pkg.sv
package scmap_pkg;

  // Angle constants in Q4.16 radians.
  localparam int TWO_PI_Q16 = 411775;
  localparam int PI_Q16 = 205887;
  localparam int HALF_PI_Q16 = 102944;

  // CORDIC start vector (inverse gain) in Q2.30.
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES = 24;

  // Only every DECIMATION-th sample produces a point.
  localparam int DECIMATION = 10;
  localparam int IDX_W = 12;
  localparam int DEC_SHIFT = 16;
  localparam int DEC_RECIP = (1 << DEC_SHIFT) / DECIMATION;
  localparam int DEC_PROD_W = IDX_W + DEC_SHIFT;

  // Field widths.
  localparam int ANGLE_IN_W = 21;
  localparam int RANGE_W = 24;
  localparam int COORD_W = 32;

  // start + step * index needs 34 signed bits.
  localparam int ANGLE_W = 34;
  // Modulo reduction works on an unsigned value below 2*pi * 2^RED_STEPS.
  localparam int RED_STEPS = 16;
  localparam int RED_PS = RED_STEPS / 2;
  localparam int RED_W = 35;
  localparam longint RED_OFFS = longint'(TWO_PI_Q16) << (RED_STEPS - 1);
  // Reduced angle, signed, wide enough for [-2*pi, 2*pi).
  localparam int FOLD_W = 21;
  localparam int ANG_RED_W = 19;
  // CORDIC datapath in Q2.30 with headroom.
  localparam int TRIG_W = 33;
  localparam int CORD_PS = (CORDIC_STAGES + 1) / 2;
  // Latency of the sine/cosine unit, input register to output register.
  localparam int SC_LAT = RED_PS + CORD_PS + 3;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_START_ANGLE = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
  localparam logic [2:0] REG_YAW_ANGLE = 3'd2;
  localparam logic [2:0] REG_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y = 3'd4;

  typedef struct packed {
    logic signed [ANGLE_IN_W-1:0] start_angle;
    logic signed [ANGLE_IN_W-1:0] angle_step;
    logic signed [ANGLE_IN_W-1:0] yaw_angle;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } cord_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
    logic signed [TRIG_W-1:0] r;
    begin
      case (i)
        0: r = TRIG_W'(843314857);
        1: r = TRIG_W'(497837829);
        2: r = TRIG_W'(263043837);
        3: r = TRIG_W'(133525159);
        4: r = TRIG_W'(67021687);
        5: r = TRIG_W'(33543516);
        6: r = TRIG_W'(16775851);
        7: r = TRIG_W'(8388437);
        8: r = TRIG_W'(4194283);
        9: r = TRIG_W'(2097149);
        10: r = TRIG_W'(1048575);
        11: r = TRIG_W'(524288);
        12: r = TRIG_W'(262144);
        13: r = TRIG_W'(131072);
        14: r = TRIG_W'(65536);
        15: r = TRIG_W'(32768);
        16: r = TRIG_W'(16384);
        17: r = TRIG_W'(8192);
        18: r = TRIG_W'(4096);
        19: r = TRIG_W'(2048);
        20: r = TRIG_W'(1024);
        21: r = TRIG_W'(512);
        22: r = TRIG_W'(256);
        23: r = TRIG_W'(128);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> design/scmap_cfg.sv
module scmap_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output scmap_pkg::cfg_t cfg
);
  import scmap_pkg::*;

  logic [2:0] reg_sel;
  logic wr_en;

  assign reg_sel = paddr[4:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_ANGLE: cfg.start_angle <= pwdata[ANGLE_IN_W-1:0];
        REG_ANGLE_STEP: cfg.angle_step <= pwdata[ANGLE_IN_W-1:0];
        REG_YAW_ANGLE: cfg.yaw_angle <= pwdata[ANGLE_IN_W-1:0];
        REG_OFFSET_X: cfg.offset_x <= pwdata;
        REG_OFFSET_Y: cfg.offset_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_ANGLE: prdata = 32'(cfg.start_angle);
      REG_ANGLE_STEP: prdata = 32'(cfg.angle_step);
      REG_YAW_ANGLE: prdata = 32'(cfg.yaw_angle);
      REG_OFFSET_X: prdata = cfg.offset_x;
      REG_OFFSET_Y: prdata = cfg.offset_y;
      default: prdata = '0;
    endcase
  end

endmodule

>>> design/scmap_sincos.sv
module scmap_sincos (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [scmap_pkg::ANGLE_W-1:0] angle,
  output logic out_valid,
  output logic signed [scmap_pkg::TRIG_W-1:0] cos_q,
  output logic signed [scmap_pkg::TRIG_W-1:0] sin_q
);
  import scmap_pkg::*;

  // Restoring modulo 2*pi, two conditional subtractions per stage.
  function automatic logic [RED_W-1:0] reduce2(input logic [RED_W-1:0] u, input int s);
    logic [RED_W-1:0] v;
    logic [RED_W-1:0] m;
    int k;
    begin
      v = u;
      for (int j = 0; j < 2; j++) begin
        k = 2 * (RED_PS - 1 - s) + 1 - j;
        m = RED_W'(TWO_PI_Q16) << k;
        if (v >= m) begin
          v = v - m;
        end
      end
      return v;
    end
  endfunction

  // Two rotation-mode iterations per stage; shifts are floor shifts.
  function automatic cord_t cord2(input cord_t c, input int s);
    cord_t r;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    int i;
    begin
      r = c;
      for (int j = 0; j < 2; j++) begin
        i = 2 * s + j;
        if (i < CORDIC_STAGES && i < ATAN_ENTRIES) begin
          dx = r.y >>> i;
          dy = r.x >>> i;
          if (!r.z[TRIG_W-1]) begin
            r.x = r.x - dx;
            r.y = r.y + dy;
            r.z = r.z - atan_q30(i);
          end else begin
            r.x = r.x + dx;
            r.y = r.y - dy;
            r.z = r.z + atan_q30(i);
          end
        end
      end
      return r;
    end
  endfunction

  logic [RED_W-1:0] red_q [0:RED_PS];
  logic red_v [0:RED_PS];
  cord_t cord_q [0:CORD_PS];
  logic cord_v [0:CORD_PS];
  logic cord_neg [0:CORD_PS];

  logic signed [FOLD_W-1:0] fa;
  logic fneg;
  cord_t fold_c;

  always_comb begin
    fa = $signed({{(FOLD_W-ANG_RED_W){1'b0}}, red_q[RED_PS][ANG_RED_W-1:0]});
    fneg = 1'b0;
    if (fa > $signed(FOLD_W'(PI_Q16))) begin
      fa = fa - $signed(FOLD_W'(TWO_PI_Q16));
    end
    if (fa > $signed(FOLD_W'(HALF_PI_Q16))) begin
      fa = fa - $signed(FOLD_W'(PI_Q16));
      fneg = 1'b1;
    end else if (fa < -$signed(FOLD_W'(HALF_PI_Q16))) begin
      fa = fa + $signed(FOLD_W'(PI_Q16));
      fneg = 1'b1;
    end
    fold_c.x = TRIG_W'(CORDIC_GAIN_Q30);
    fold_c.y = '0;
    fold_c.z = TRIG_W'(fa) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= RED_PS; s++) begin
        red_v[s] <= 1'b0;
      end
      for (int s = 0; s <= CORD_PS; s++) begin
        cord_v[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      red_v[0] <= in_valid;
      for (int s = 0; s < RED_PS; s++) begin
        red_v[s+1] <= red_v[s];
      end
      cord_v[0] <= red_v[RED_PS];
      for (int s = 0; s < CORD_PS; s++) begin
        cord_v[s+1] <= cord_v[s];
      end
      out_valid <= cord_v[CORD_PS];
    end
  end

  always_ff @(posedge clk) begin
    red_q[0] <= {angle[ANGLE_W-1], angle} + RED_W'(RED_OFFS);
    for (int s = 0; s < RED_PS; s++) begin
      red_q[s+1] <= reduce2(red_q[s], s);
    end
    cord_q[0] <= fold_c;
    cord_neg[0] <= fneg;
    for (int s = 0; s < CORD_PS; s++) begin
      cord_q[s+1] <= cord2(cord_q[s], s);
      cord_neg[s+1] <= cord_neg[s];
    end
    cos_q <= cord_neg[CORD_PS] ? -cord_q[CORD_PS].x : cord_q[CORD_PS].x;
    sin_q <= cord_neg[CORD_PS] ? -cord_q[CORD_PS].y : cord_q[CORD_PS].y;
  end

endmodule

>>> design/scmap_xform.sv
module scmap_xform (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [scmap_pkg::RANGE_W-1:0] range_q,
  input  logic [scmap_pkg::IDX_W-1:0] idx,
  input  logic signed [scmap_pkg::TRIG_W-1:0] cb,
  input  logic signed [scmap_pkg::TRIG_W-1:0] sb,
  input  logic signed [scmap_pkg::TRIG_W-1:0] cy,
  input  logic signed [scmap_pkg::TRIG_W-1:0] sy,
  input  logic signed [scmap_pkg::COORD_W-1:0] offset_x,
  input  logic signed [scmap_pkg::COORD_W-1:0] offset_y,
  output logic out_valid,
  output logic signed [scmap_pkg::COORD_W-1:0] px,
  output logic signed [scmap_pkg::COORD_W-1:0] py,
  output logic [scmap_pkg::IDX_W-1:0] pidx
);
  import scmap_pkg::*;

  localparam int P1_W = RANGE_W + 1 + TRIG_W;
  localparam int XS_W = RANGE_W + 2;
  localparam int P2_W = XS_W + TRIG_W;
  localparam int P3_W = P2_W + 1;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [P3_W-1:0] v);
    logic signed [P3_W-1:0] hi;
    logic signed [P3_W-1:0] lo;
    begin
      hi = $signed(P3_W'(32'h7fffffff));
      lo = ~hi;
      if (v > hi) begin
        return hi[COORD_W-1:0];
      end else if (v < lo) begin
        return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
    end
  endfunction

  logic signed [P1_W-1:0] mc;
  logic signed [P1_W-1:0] ms;
  logic signed [P1_W-1:0] rng_s;
  logic signed [P3_W-1:0] sx;
  logic signed [P3_W-1:0] sy3;

  logic v1, v2;
  logic [IDX_W-1:0] idx1, idx2;
  logic signed [XS_W-1:0] xs, ys;
  logic signed [TRIG_W-1:0] cy1, sy1;
  logic signed [P2_W-1:0] p_xc, p_ys, p_xs, p_yc;

  always_comb begin
    rng_s = $signed(P1_W'(range_q));
    mc = ((rng_s * P1_W'(cb)) + P1_W'(1 << 29)) >>> 30;
    ms = ((rng_s * P1_W'(sb)) + P1_W'(1 << 29)) >>> 30;
    sx = ((P3_W'(p_xc) - P3_W'(p_ys) + P3_W'(1 << 29)) >>> 30) + P3_W'(offset_x);
    sy3 = ((P3_W'(p_xs) + P3_W'(p_yc) + P3_W'(1 << 29)) >>> 30) + P3_W'(offset_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    xs <= mc[XS_W-1:0];
    ys <= ms[XS_W-1:0];
    cy1 <= cy;
    sy1 <= sy;
    idx1 <= idx;
    p_xc <= P2_W'(xs) * P2_W'(cy1);
    p_ys <= P2_W'(ys) * P2_W'(sy1);
    p_xs <= P2_W'(xs) * P2_W'(sy1);
    p_yc <= P2_W'(ys) * P2_W'(cy1);
    idx2 <= idx1;
    px <= sat32(sx);
    py <= sat32(sy3);
    pidx <= idx2;
  end

endmodule

>>> design/scan_polar_to_map_transform_core.sv
// Laser-scan sample to map point, fully pipelined.
// Pipeline: 1 entry stage, 19 in the sine/cosine unit and 3 in the transform; done is
// registered in the same stage as the point.
// Throughput: one sample per clock; busy is always low and the receiver cannot stall.
// Reset (rst, synchronous, active high) clears the configuration and every valid bit,
// which empties the pipeline; data registers are not reset and need no clearing pass.
module scan_polar_to_map_transform_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [scmap_pkg::RANGE_W-1:0] range_value,
  input  logic range_invalid,
  input  logic [scmap_pkg::IDX_W-1:0] sample_index,
  output logic done,
  output logic signed [scmap_pkg::COORD_W-1:0] point_x,
  output logic signed [scmap_pkg::COORD_W-1:0] point_y,
  output logic [scmap_pkg::IDX_W-1:0] point_index,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import scmap_pkg::*;

  cfg_t cfg;

  // Every stage advances each cycle, so a new transaction is always welcome.
  assign busy = 1'b0;

  scmap_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Decimation test: the index remainder comes from a reciprocal multiply
  // followed by a single correction step.
  logic [DEC_PROD_W-1:0] dec_prod;
  logic [IDX_W-1:0] dec_q;
  logic [DEC_PROD_W-1:0] dec_rem;
  logic dec_ok;

  always_comb begin
    dec_prod = DEC_PROD_W'(sample_index) * DEC_PROD_W'(DEC_RECIP);
    dec_q = dec_prod[DEC_PROD_W-1:DEC_SHIFT];
    dec_rem = DEC_PROD_W'(sample_index) - DEC_PROD_W'(dec_q) * DEC_PROD_W'(DECIMATION);
    if (dec_rem >= DEC_PROD_W'(DECIMATION)) begin
      dec_rem = dec_rem - DEC_PROD_W'(DECIMATION);
    end
    dec_ok = (dec_rem == '0);
  end

  // Entry stage: beam angle, range with invalid readings forced to zero.
  // Samples that are dropped by decimation still flow, with the valid bit low.
  logic v1;
  logic signed [ANGLE_W-1:0] beam_ang;
  logic [RANGE_W-1:0] range1;
  logic [IDX_W-1:0] idx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy & dec_ok;
    end
  end

  always_ff @(posedge clk) begin
    beam_ang <= ANGLE_W'(cfg.start_angle)
              + ANGLE_W'(cfg.angle_step) * $signed(ANGLE_W'(sample_index));
    range1 <= range_invalid ? '0 : range_value;
    idx1 <= sample_index;
  end

  // Two sine/cosine units: one for the beam, one for the mounting yaw.
  logic sc_bv, sc_yv;
  logic signed [TRIG_W-1:0] cb, sb, cy, sy;

  scmap_sincos u_beam (
    .clk(clk), .rst(rst), .in_valid(v1), .angle(beam_ang),
    .out_valid(sc_bv), .cos_q(cb), .sin_q(sb)
  );

  scmap_sincos u_yaw (
    .clk(clk), .rst(rst), .in_valid(v1), .angle(ANGLE_W'(cfg.yaw_angle)),
    .out_valid(sc_yv), .cos_q(cy), .sin_q(sy)
  );

  // Range and index ride alongside the sine/cosine unit.
  logic [RANGE_W-1:0] rng_d [0:SC_LAT-1];
  logic [IDX_W-1:0] idx_d [0:SC_LAT-1];

  always_ff @(posedge clk) begin
    rng_d[0] <= range1;
    idx_d[0] <= idx1;
    for (int s = 1; s < SC_LAT; s++) begin
      rng_d[s] <= rng_d[s-1];
      idx_d[s] <= idx_d[s-1];
    end
  end

  // Polar to sensor frame, rotation by yaw, translation and saturation.
  scmap_xform u_xform (
    .clk(clk), .rst(rst), .in_valid(sc_bv & sc_yv),
    .range_q(rng_d[SC_LAT-1]), .idx(idx_d[SC_LAT-1]),
    .cb(cb), .sb(sb), .cy(cy), .sy(sy),
    .offset_x(cfg.offset_x), .offset_y(cfg.offset_y),
    .out_valid(done), .px(point_x), .py(point_y), .pidx(point_index)
  );

endmodule

>>> bench/tb_scan_polar_to_map_transform_core.sv
`timescale 1ns / 1ps

module tb_scan_polar_to_map_transform_core;
  import scmap_pkg::*;

  // Drain wait before a register write: samples that produce no point may
  // still be moving through the pipeline.
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_ROWS = 12;
  // Addresses of register indexes that do not exist; writes must be ignored.
  localparam logic [2:0] REG_UNUSED_5 = 3'd5;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [IDX_W-1:0] idx;
  } map_point_t;

  // One row of the directed table. A row marked typed carries the point that
  // the block must give; the others are checked against the predictor.
  typedef struct {
    logic [RANGE_W-1:0] range_v;
    logic invalid;
    logic [IDX_W-1:0] idx;
    bit typed;
    bit gives_point;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } sample_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [RANGE_W-1:0] range_value;
  logic range_invalid;
  logic [IDX_W-1:0] sample_index;
  logic done;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [IDX_W-1:0] point_index;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the configuration, kept in step with every register write.
  longint sh_start_angle;
  longint sh_angle_step;
  longint sh_yaw_angle;
  longint sh_offset_x;
  longint sh_offset_y;

  map_point_t expected_points[$];
  int mismatches;

  // A typed expectation handed from the driver to the acceptance monitor.
  bit typed_active;
  sample_row_t typed_row;

  int idle_pct;

  // Arctangent table in Q2.30, entry i for CORDIC iteration i.
  localparam longint ATAN_TABLE [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  scan_polar_to_map_transform_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .range_value(range_value),
    .range_invalid(range_invalid),
    .sample_index(sample_index),
    .done(done),
    .point_x(point_x),
    .point_y(point_y),
    .point_index(point_index),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Cosine and sine of a Q4.16 angle of any size, both in Q2.30. The angle is
  // reduced into (-pi, pi], folded into [-pi/2, pi/2] with a sign flip, and
  // then rotated by CORDIC. Arithmetic right shifts on longint floor.
  function automatic void beam_cos_sin(input longint ang, output longint c,
                                       output longint s);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    a = ang % longint'(TWO_PI_Q16);
    flip = 1'b0;
    x = CORDIC_GAIN_Q30;
    y = 0;
    if (a < 0) a += TWO_PI_Q16;
    if (a > PI_Q16) a -= TWO_PI_Q16;
    if (a > HALF_PI_Q16) begin
      a -= PI_Q16;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q16) begin
      a += PI_Q16;
      flip = 1'b1;
    end
    z = a * 16384;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TABLE[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TABLE[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Predicts the map point of one sample; returns 0 when the sample is dropped.
  function automatic bit map_point_of(input logic [RANGE_W-1:0] rv, input logic inv,
                                      input logic [IDX_W-1:0] idx,
                                      output map_point_t p);
    longint r;
    longint cb;
    longint sb;
    longint cy;
    longint sy;
    longint xs;
    longint ys;
    longint xm;
    longint ym;
    if ((idx % DECIMATION) != 0) return 1'b0;
    r = inv ? 0 : longint'(rv);
    beam_cos_sin(sh_start_angle + sh_angle_step * longint'(idx), cb, sb);
    beam_cos_sin(sh_yaw_angle, cy, sy);
    xs = (r * cb + (64'sd1 << 29)) >>> 30;
    ys = (r * sb + (64'sd1 << 29)) >>> 30;
    xm = ((xs * cy - ys * sy + (64'sd1 << 29)) >>> 30) + sh_offset_x;
    ym = ((xs * sy + ys * cy + (64'sd1 << 29)) >>> 30) + sh_offset_y;
    p.x = COORD_W'(clamp32(xm));
    p.y = COORD_W'(clamp32(ym));
    p.idx = idx;
    return 1'b1;
  endfunction

  // Acceptance and result monitor. Results are checked before new samples are
  // queued; the pipeline depth keeps the two apart anyway.
  always @(posedge clk) begin
    map_point_t want;
    if (!rst) begin
      if (done) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected point x=%0d y=%0d index=%0d", point_x, point_y, point_index);
        end else begin
          want = expected_points.pop_front();
          if (point_x !== want.x || point_y !== want.y || point_index !== want.idx) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("point mismatch: expected x=%0d y=%0d index=%0d, got x=%0d y=%0d index=%0d",
                       want.x, want.y, want.idx, point_x, point_y, point_index);
          end
        end
      end
      if (start && !busy) begin
        if (typed_active) begin
          if (typed_row.gives_point) begin
            want.x = typed_row.x;
            want.y = typed_row.y;
            want.idx = typed_row.idx;
            expected_points = {expected_points, want};
          end
        end else if (map_point_of(range_value, range_invalid, sample_index, want)) begin
          expected_points = {expected_points, want};
        end
      end
    end
  end

  // Offers one sample from the next falling edge and holds it until accepted.
  task automatic send_sample(input logic [RANGE_W-1:0] rv, input logic inv,
                             input logic [IDX_W-1:0] idx, input bit typed,
                             input sample_row_t row);
    @(negedge clk);
    typed_active = typed;
    typed_row = row;
    start <= 1'b1;
    range_value <= rv;
    range_invalid <= inv;
    sample_index <= idx;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      start <= 1'b0;
      range_value <= RANGE_W'($urandom);
      range_invalid <= 1'($urandom);
      sample_index <= IDX_W'($urandom);
    end
  endtask

  // Holds the sender off until every expected point has come out, then lets
  // the dropped samples still in flight leave the pipeline.
  task automatic wait_quiet();
    idle_cycles(1);
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [2:0] index, input longint value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_START_ANGLE: sh_start_angle = value;
      REG_ANGLE_STEP: sh_angle_step = value;
      REG_YAW_ANGLE: sh_yaw_angle = value;
      REG_OFFSET_X: sh_offset_x = value;
      REG_OFFSET_Y: sh_offset_y = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input longint sa, input longint st, input longint yw,
                           input longint ox, input longint oy);
    write_reg(REG_START_ANGLE, sa);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_YAW_ANGLE, yw);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
  endtask

  function automatic longint rand_angle();
    return longint'($urandom_range(2097151)) - 1048576;
  endfunction

  function automatic longint rand_offset();
    return longint'(int'($urandom));
  endfunction

  sample_row_t rows [NUM_ROWS];

  initial begin
    sample_row_t none_row;
    logic [RANGE_W-1:0] rv;
    logic [IDX_W-1:0] idx;
    none_row = '{default: '0};
    sh_start_angle = 0;
    sh_angle_step = 0;
    sh_yaw_angle = 0;
    sh_offset_x = 0;
    sh_offset_y = 0;
    mismatches = 0;
    typed_active = 1'b0;
    typed_row = none_row;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    range_value = '0;
    range_invalid = 1'b0;
    sample_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Directed table, run with the reset configuration. With all registers at
    // zero an invalid reading or a zero range lands exactly on the origin, and
    // indexes off the decimation grid give nothing.
    rows[0] = '{24'd0, 1'b0, 12'd0, 1'b1, 1'b1, 32'sd0, 32'sd0};
    rows[1] = '{24'hFFFFFF, 1'b1, 12'd0, 1'b1, 1'b1, 32'sd0, 32'sd0};
    rows[2] = '{24'hFFFFFF, 1'b1, 12'd4090, 1'b1, 1'b1, 32'sd0, 32'sd0};
    rows[3] = '{24'h123456, 1'b0, 12'd7, 1'b1, 1'b0, 32'sd0, 32'sd0};
    rows[4] = '{24'h000001, 1'b0, 12'd4095, 1'b1, 1'b0, 32'sd0, 32'sd0};
    rows[5] = '{24'hFFFFFF, 1'b0, 12'd2048, 1'b1, 1'b0, 32'sd0, 32'sd0};
    rows[6] = '{24'hFFFFFF, 1'b0, 12'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
    rows[7] = '{24'hFFFFFF, 1'b0, 12'd4090, 1'b0, 1'b0, 32'sd0, 32'sd0};
    rows[8] = '{24'h800000, 1'b0, 12'd10, 1'b0, 1'b0, 32'sd0, 32'sd0};
    rows[9] = '{24'h000001, 1'b0, 12'd2040, 1'b0, 1'b0, 32'sd0, 32'sd0};
    rows[10] = '{24'h555555, 1'b0, 12'd1370, 1'b0, 1'b0, 32'sd0, 32'sd0};
    rows[11] = '{24'hAAAAAA, 1'b0, 12'd2730, 1'b0, 1'b0, 32'sd0, 32'sd0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_sample(rows[i].range_v, rows[i].invalid, rows[i].idx, rows[i].typed, rows[i]);
    wait_quiet();

    // The same few samples again under extreme registers, where the offsets
    // push the points into saturation. Writes to missing indexes must change
    // nothing.
    write_all(-1048576, 1048575, 1048575, 64'sd2147483647, -64'sd2147483648);
    write_reg(REG_UNUSED_5, 0);
    write_reg(REG_UNUSED_7, 32'h1234);
    for (int i = 6; i < NUM_ROWS; i++)
      send_sample(rows[i].range_v, rows[i].invalid, rows[i].idx, 1'b0, none_row);
    wait_quiet();

    // Random phases. Most samples sit on the decimation grid so that points
    // come out often; the rest are dropped. Sender idling varies by phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_all(1048575, -1048576, -1048576, -64'sd2147483648, 64'sd2147483647);
        1: write_all(0, 0, 0, 0, 0);
        default: write_all(rand_angle(), rand_angle(), rand_angle(), rand_offset(),
                            rand_offset());
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 59;
        2: idle_pct = 19;
        default: idle_pct = 59;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: rv = 24'hFFFFFF;
          1: rv = 24'd0;
          2: rv = RANGE_W'($urandom_range(65535));
          default: rv = RANGE_W'($urandom);
        endcase
        if ($urandom_range(9) < 7)
          idx = IDX_W'($urandom_range(409) * DECIMATION);
        else
          idx = IDX_W'($urandom);
        send_sample(rv, ($urandom_range(9) == 0), idx, 1'b0, none_row);
        // A stretch without gaps every so often, even in the idling phases.
        if (idle_pct != 0 && (n % 20) < 15 && $urandom_range(99) < idle_pct)
          idle_cycles($urandom_range(4, 1));
        // Once in the middle of each phase the sender holds off until the pipeline is empty.
        if (n == ITEMS_PER_PHASE / 2)
          wait_quiet();
      end
      wait_quiet();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
